>>> rtl/rwac_pkg.sv
// shared types, constants and helpers for the range-wrapped arithmetic counter
`timescale 1ns / 1ps

package rwac_pkg;

  // counter datapath width (8 to 32); bits above it in operand and bounds are ignored
  localparam int DATA_WIDTH = 32;
  localparam int WIDE_WIDTH = 2 * DATA_WIDTH;
  localparam int CNT_WIDTH  = $clog2(WIDE_WIDTH + 1);
  localparam int ADDR_WIDTH = 3;

  // operation codes
  typedef enum logic [2:0] {
    KIND_SET = 3'd0,
    KIND_ADD = 3'd1,
    KIND_SUB = 3'd2,
    KIND_MUL = 3'd3,
    KIND_DIV = 3'd4
  } kind_e;

  // register select, taken from paddr[2]
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  // input transfer payload
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] operand;
  } in_item_t;

  // output transfer payload
  typedef struct packed {
    logic signed [31:0] count_value;
    logic               op_error;
  } out_item_t;

  // divider request and status
  typedef struct packed {
    logic                 start;
    logic [CNT_WIDTH-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sign extend a datapath value to a 32-bit word
  function automatic logic [31:0] to_word(logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] s;
    s = signed'(v);
    return 32'(s);
  endfunction

endpackage

>>> rtl/rwac_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rwac_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rwac_pkg::div_req_t               req_i,
  input  logic [rwac_pkg::WIDE_WIDTH-1:0]  dividend_i,
  input  logic [rwac_pkg::DATA_WIDTH-1:0]  divisor_i,
  output rwac_pkg::div_stat_t              stat_o,
  output logic [rwac_pkg::DATA_WIDTH-1:0]  quotient_o,
  output logic [rwac_pkg::DATA_WIDTH-1:0]  remainder_o
);
  import rwac_pkg::*;

  logic                  busy_q, busy_d;
  logic [CNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic [WIDE_WIDTH-1:0] num_q, num_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] den_q, den_d;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] sub;
  logic                  ge;
  logic                  done;

  // one shift-subtract step
  assign trial = {rem_q, num_q[WIDE_WIDTH-1]};
  assign sub   = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~sub[DATA_WIDTH+1];
  assign done  = busy_q && (cnt_q == '0);

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      num_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_WIDTH'(1);
      num_d = {num_q[WIDE_WIDTH-2:0], ge};
      rem_d = ge ? sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done;
  assign quotient_o   = num_q[DATA_WIDTH-1:0];
  assign remainder_o  = rem_q;

endmodule

>>> rtl/range_wrapped_arithmetic_counter_unit.sv
// top level of the range-wrapped arithmetic counter
`timescale 1ns / 1ps

// Keeps one signed counter inside [lower_bound, upper_bound) and applies set, add,
// subtract, multiply or truncating divide with each input transfer, then reduces
// the exact result into the range by floor modulo. One item is in work at a time;
// the input stalls until the item reaches the output register. The reduction runs
// the shared radix-2 divider for 2*DATA_WIDTH iterations; set, add, subtract and
// multiply form the exact result in the raw state before it, while divide first runs
// the divider for DATA_WIDTH iterations to form the quotient. An empty range, divide
// by zero or an unknown kind goes straight to the final state that loads the output
// register. The next item is taken from the cycle after the result is registered.
// A result may wait at the output while the next item is already accepted.
// Writing either bound reloads the counter to 0 if 0 lies in range, else to lower.
module range_wrapped_arithmetic_counter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rwac_pkg::in_item_t              in_item_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rwac_pkg::out_item_t             out_item_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rwac_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rwac_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RAW  = 6'b000010,
    ST_QDIV = 6'b000100,
    ST_DIFF = 6'b001000,
    ST_RDIV = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [DATA_WIDTH-1:0] lower_q, lower_d;
  logic signed [DATA_WIDTH-1:0] upper_q, upper_d;
  logic signed [DATA_WIDTH-1:0] cur_q, cur_d;
  logic [2:0]                   kind_q, kind_d;
  logic signed [DATA_WIDTH-1:0] opnd_q, opnd_d;
  logic [DATA_WIDTH-1:0]        size_q, size_d;
  logic signed [WIDE_WIDTH-1:0] raw_q, raw_d;
  logic [DATA_WIDTH-1:0]        red_q, red_d;
  logic                         neg_q, neg_d;
  logic                         err_q, err_d;
  logic                         apply_q, apply_d;
  logic                         out_valid_q, out_valid_d;
  out_item_t                    out_item_q, out_item_d;

  logic                         in_acc;
  logic                         cfg_wr;
  logic                         fin_go;
  logic signed [DATA_WIDTH-1:0] opnd_in;
  logic signed [DATA_WIDTH:0]   span;
  logic                         empty;
  logic [DATA_WIDTH-1:0]        cur_mag;
  logic [DATA_WIDTH-1:0]        opnd_mag;
  logic signed [WIDE_WIDTH-1:0] prod;
  logic signed [WIDE_WIDTH:0]   diff;
  logic [WIDE_WIDTH:0]          diff_mag;
  logic [WIDE_WIDTH-1:0]        quot_wide;
  logic [DATA_WIDTH-1:0]        new_val;

  div_req_t                     div_req;
  div_stat_t                    div_stat;
  logic [WIDE_WIDTH-1:0]        div_dividend;
  logic [DATA_WIDTH-1:0]        div_divisor;
  logic [DATA_WIDTH-1:0]        div_quot;
  logic [DATA_WIDTH-1:0]        div_rem;

  // handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fin_go     = !out_valid_q || !out_stall_i;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;

  // operand decode and range size
  assign opnd_in  = signed'(in_item_i.operand[DATA_WIDTH-1:0]);
  assign span     = (DATA_WIDTH+1)'(upper_q) - (DATA_WIDTH+1)'(lower_q);
  assign empty    = span[DATA_WIDTH] || (span == '0);
  assign cur_mag  = cur_q[DATA_WIDTH-1] ? -cur_q : cur_q;
  assign opnd_mag = opnd_in[DATA_WIDTH-1] ? -opnd_in : opnd_in;

  // exact product, offset from lower bound and its magnitude
  assign prod      = cur_q * opnd_q;
  assign diff      = (WIDE_WIDTH+1)'(raw_q) - (WIDE_WIDTH+1)'(lower_q);
  assign diff_mag  = diff[WIDE_WIDTH] ? -diff : diff;
  assign quot_wide = {{DATA_WIDTH{1'b0}}, div_quot};
  assign new_val   = lower_q + red_q;

  // divider request
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = CNT_WIDTH'(WIDE_WIDTH);
    div_dividend  = diff_mag[WIDE_WIDTH-1:0];
    div_divisor   = size_q;
    if (state_q == ST_IDLE) begin
      div_req.start = in_acc && !empty && (in_item_i.kind == KIND_DIV) && (opnd_in != '0);
      div_req.iters = CNT_WIDTH'(DATA_WIDTH);
      div_dividend  = {cur_mag, {DATA_WIDTH{1'b0}}};
      div_divisor   = opnd_mag;
    end else if (state_q == ST_DIFF) begin
      div_req.start = 1'b1;
    end
  end

  rwac_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    cur_d       = cur_q;
    kind_d      = kind_q;
    opnd_d      = opnd_q;
    size_d      = size_q;
    raw_d       = raw_q;
    red_d       = red_q;
    neg_d       = neg_q;
    err_d       = err_q;
    apply_d     = apply_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          kind_d  = in_item_i.kind;
          opnd_d  = opnd_in;
          size_d  = span[DATA_WIDTH-1:0];
          neg_d   = cur_q[DATA_WIDTH-1] ^ opnd_in[DATA_WIDTH-1];
          err_d   = 1'b0;
          apply_d = 1'b1;
          state_d = ST_RAW;
          if (empty) begin
            err_d   = 1'b1;
            apply_d = 1'b0;
            state_d = ST_FIN;
          end else begin
            case (in_item_i.kind) inside
              KIND_SET, KIND_ADD, KIND_SUB, KIND_MUL: state_d = ST_RAW;
              KIND_DIV: begin
                if (opnd_in == '0) begin
                  err_d   = 1'b1;
                  apply_d = 1'b0;
                  state_d = ST_FIN;
                end else begin
                  state_d = ST_QDIV;
                end
              end
              default: begin
                apply_d = 1'b0;
                state_d = ST_FIN;
              end
            endcase
          end
        end
      end
      ST_RAW: begin
        case (kind_q)
          KIND_SET: raw_d = WIDE_WIDTH'(opnd_q);
          KIND_ADD: raw_d = WIDE_WIDTH'(cur_q) + WIDE_WIDTH'(opnd_q);
          KIND_SUB: raw_d = WIDE_WIDTH'(cur_q) - WIDE_WIDTH'(opnd_q);
          KIND_MUL: raw_d = prod;
          default:  raw_d = raw_q;
        endcase
        state_d = ST_DIFF;
      end
      ST_QDIV: begin
        if (div_stat.done) begin
          raw_d   = neg_q ? -signed'(quot_wide) : signed'(quot_wide);
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        neg_d   = diff[WIDE_WIDTH];
        state_d = ST_RDIV;
      end
      ST_RDIV: begin
        if (div_stat.done) begin
          // floor modulo: fold a negative offset's remainder back into the range
          red_d   = (neg_q && (div_rem != '0)) ? size_q - div_rem : div_rem;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          if (apply_q) begin
            cur_d = new_val;
          end
          out_valid_d            = 1'b1;
          out_item_d.count_value = to_word(apply_q ? new_val : cur_q);
          out_item_d.op_error    = err_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // bound writes reload the counter
    if (cfg_wr) begin
      if (paddr[2] == REG_UPPER) begin
        upper_d = signed'(pwdata[DATA_WIDTH-1:0]);
      end else begin
        lower_d = signed'(pwdata[DATA_WIDTH-1:0]);
      end
      cur_d = ((lower_d <= 0) && (upper_d > 0)) ? '0 : lower_d;
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lower_q     <= '0;
      upper_q     <= DATA_WIDTH'(256);
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lower_q     <= lower_d;
      upper_q     <= upper_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    opnd_q     <= opnd_d;
    size_q     <= size_d;
    raw_q      <= raw_d;
    red_q      <= red_d;
    neg_q      <= neg_d;
    err_q      <= err_d;
    apply_q    <= apply_d;
    out_item_q <= out_item_d;
  end

  // outputs
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign prdata      = (paddr[2] == REG_UPPER) ? to_word(upper_q) : to_word(lower_q);

  // divider is never restarted while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // sequencer only waits on a running divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QDIV || state_q == ST_RDIV) |-> div_stat.busy)
    else $error("waiting on idle divider");

  // range reduction remainder stays below the range size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDIV && div_stat.done) |-> (div_rem < size_q))
    else $error("remainder not below range size");

endmodule

>>> test/tb_top.sv
// testbench for the range-wrapped arithmetic counter: directed table, random phases, predictor
`timescale 1ns / 1ps

module tb_top;
  import rwac_pkg::*;

  // kind codes with no operation behind them
  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

  localparam int  NUM_PHASES    = 12;
  localparam int  PHASE_ITEMS   = 138;
  localparam int  EMPTY_ITEMS   = 20;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  DRAIN_CYCLES  = 120;
  localparam int  HOLD_CYCLES   = 400;
  localparam int  LIMIT_CYCLES  = 1500000;
  localparam int  PLAN_LEN      = 32;

  // directed table rows: one input transfer or one bound write
  typedef enum logic [1:0] {
    ACT_ITEM  = 2'd0,
    ACT_LOWER = 2'd1,
    ACT_UPPER = 2'd2
  } step_act_e;

  typedef struct packed {
    step_act_e   act;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        typed;
    logic [31:0] exp_count;
    logic        exp_err;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  range_wrapped_arithmetic_counter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predicted block state
  longint    pred_lower;
  longint    pred_upper;
  longint    pred_count;
  out_item_t pending_counts[$];

  bit        no_idle;
  bit        hold_req;
  int        fail_cnt;
  int        n_in;
  int        n_out;
  int        n_rejected;
  int        n_cfg;
  int        cycle_cnt;

  // directed stimulus, expected values typed where they are obvious
  step_t plan [0:PLAN_LEN-1] = '{
    '{ACT_ITEM,  KIND_SET, 32'd5,          1'b1, 32'd5,          1'b0},
    '{ACT_ITEM,  KIND_ADD, 32'd300,        1'b1, 32'd49,         1'b0},
    '{ACT_ITEM,  KIND_SUB, 32'd100,        1'b1, 32'd205,        1'b0},
    '{ACT_ITEM,  KIND_MUL, 32'd3,          1'b1, 32'd103,        1'b0},
    '{ACT_ITEM,  KIND_DIV, 32'd2,          1'b1, 32'd51,         1'b0},
    '{ACT_ITEM,  KIND_DIV, 32'd0,          1'b1, 32'd51,         1'b1},
    '{ACT_ITEM,  KIND_DIV, 32'hFFFF_FFFE,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_RSVD_FIRST, 32'd9,   1'b1, 32'd231,        1'b0},
    '{ACT_ITEM,  KIND_SET, 32'h7FFF_FFFF,  1'b1, 32'd255,        1'b0},
    '{ACT_ITEM,  KIND_SET, 32'h8000_0000,  1'b1, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_MUL, 32'h8000_0000,  1'b1, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_SET, 32'hFFFF_FFFF,  1'b1, 32'd255,        1'b0},
    '{ACT_ITEM,  KIND_MUL, 32'h7FFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{ACT_LOWER, KIND_SET, 32'h8000_0000,  1'b0, 32'd0,          1'b0},
    '{ACT_UPPER, KIND_SET, 32'h7FFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_SET, 32'h8000_0000,  1'b1, 32'h8000_0000,  1'b0},
    '{ACT_ITEM,  KIND_DIV, 32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_SUB, 32'h7FFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_MUL, 32'h8000_0000,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_ADD, 32'h7FFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{ACT_UPPER, KIND_SET, 32'h8000_0000,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_ADD, 32'd1,          1'b1, 32'h8000_0000,  1'b1},
    '{ACT_ITEM,  KIND_DIV, 32'd0,          1'b1, 32'h8000_0000,  1'b1},
    '{ACT_ITEM,  KIND_RSVD_LAST, 32'd0,    1'b1, 32'h8000_0000,  1'b1},
    '{ACT_LOWER, KIND_SET, 32'd100,        1'b0, 32'd0,          1'b0},
    '{ACT_UPPER, KIND_SET, 32'd101,        1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_ADD, 32'd12345,      1'b1, 32'd100,        1'b0},
    '{ACT_ITEM,  KIND_DIV, 32'd7,          1'b1, 32'd100,        1'b0},
    '{ACT_LOWER, KIND_SET, 32'hFFFF_FFF6,  1'b0, 32'd0,          1'b0},
    '{ACT_UPPER, KIND_SET, 32'hFFFF_FFFD,  1'b0, 32'd0,          1'b0},
    '{ACT_ITEM,  KIND_SUB, 32'd1,          1'b1, 32'hFFFF_FFFC,  1'b0},
    '{ACT_ITEM,  KIND_MUL, 32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0}
  };

  // clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // low bits of a word as a signed datapath value
  function automatic longint to_dw(logic [31:0] v);
    logic signed [DATA_WIDTH-1:0] s;
    s = v[DATA_WIDTH-1:0];
    return s;
  endfunction

  // counter value after a bound write
  function automatic void reload_count();
    if (pred_lower <= 0 && pred_upper > 0) begin
      pred_count = 0;
    end else begin
      pred_count = pred_lower;
    end
  endfunction

  // floor modulo into [lower, upper)
  function automatic longint wrap_into_range(longint raw);
    longint span;
    longint r;
    span = pred_upper - pred_lower;
    r = (raw - pred_lower) % span;
    if (r < 0) begin
      r += span;
    end
    return pred_lower + r;
  endfunction

  // applies one operation to the predicted counter and returns the result transfer
  function automatic out_item_t apply_op(in_item_t item);
    longint    opnd;
    longint    cur;
    longint    raw;
    bit        err;
    bit        upd;
    out_item_t res;
    opnd = to_dw(item.operand);
    cur  = pred_count;
    raw  = cur;
    err  = 1'b0;
    upd  = 1'b1;
    if (pred_upper <= pred_lower) begin
      err = 1'b1;
      upd = 1'b0;
    end else begin
      case (item.kind)
        KIND_SET: raw = opnd;
        KIND_ADD: raw = cur + opnd;
        KIND_SUB: raw = cur - opnd;
        KIND_MUL: raw = cur * opnd;
        KIND_DIV: begin
          if (opnd == 0) begin
            err = 1'b1;
            upd = 1'b0;
          end else begin
            raw = cur / opnd;
          end
        end
        default: upd = 1'b0;
      endcase
    end
    if (upd) begin
      pred_count = wrap_into_range(raw);
    end
    res.count_value = 32'(pred_count);
    res.op_error    = err;
    return res;
  endfunction

  // idle cycles before the next transfer on either side
  function automatic int draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // random input with operands biased toward edges and the current range
  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 19) == 0) begin
      it.kind = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    end else begin
      it.kind = 3'($urandom_range(KIND_SET, KIND_DIV));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.operand = $urandom_range(0, 40) - 20;
      4, 5, 6:    it.operand = $urandom;
      7: begin
        case ($urandom_range(0, 4))
          0:       it.operand = 32'h8000_0000;
          1:       it.operand = 32'h7FFF_FFFF;
          2:       it.operand = 32'd0;
          3:       it.operand = 32'd1;
          default: it.operand = 32'hFFFF_FFFF;
        endcase
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          it.operand = 32'(pred_lower + longint'($urandom_range(0, 3)));
        end else begin
          it.operand = 32'(pred_upper - longint'($urandom_range(0, 3)));
        end
      end
      default: it.operand = $urandom_range(0, 65535) - 32768;
    endcase
    return it;
  endfunction

  // offers one input transfer and records its expected result once accepted
  task automatic send_item(in_item_t item, logic typed, logic [31:0] exp_count,
                           logic exp_err);
    int        gap;
    out_item_t exp;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp = apply_op(item);
    if (typed) begin
      exp.count_value = exp_count;
      exp.op_error    = exp_err;
    end
    pending_counts.push_back(exp);
    n_in++;
  endtask

  // writes one bound once the block is idle, then reads it back
  task automatic write_bound(logic reg_sel, logic [31:0] value);
    logic [31:0] rd;
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'({reg_sel, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_sel == REG_LOWER) begin
      pred_lower = to_dw(value);
    end else begin
      pred_upper = to_dw(value);
    end
    reload_count();
    n_cfg++;
    // read back in a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    if (rd !== 32'(to_dw(value))) begin
      $error("prdata: expected %0h, actual %0h", 32'(to_dw(value)), rd);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: checks each accepted transfer and draws its own stalls
  initial begin : result_sink
    int        stall_cnt;
    out_item_t exp;
    stall_cnt = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) begin
          n_out++;
          if (out_item_o.op_error) begin
            n_rejected++;
          end
          if (pending_counts.size() == 0) begin
            $error("unexpected result transfer: count_value %0d op_error %0b",
                   $signed(out_item_o.count_value), out_item_o.op_error);
            fail_cnt++;
          end else begin
            exp = pending_counts.pop_front();
            if (out_item_o.count_value !== exp.count_value) begin
              $error("count_value: expected %0d, actual %0d",
                     $signed(exp.count_value), $signed(out_item_o.count_value));
              fail_cnt++;
            end
            if (out_item_o.op_error !== exp.op_error) begin
              $error("op_error: expected %0b, actual %0b",
                     exp.op_error, out_item_o.op_error);
              fail_cnt++;
            end
          end
          stall_cnt = draw_wait();
        end else if (stall_cnt > 0) begin
          stall_cnt--;
        end
        // long hold-off so the block backs up into its input
        if (hold_req) begin
          hold_req  = 1'b0;
          stall_cnt = HOLD_CYCLES;
        end
        out_stall_i <= (stall_cnt > 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // reset, directed table, random phases, drain
  initial begin : stimulus
    logic [31:0] lo_b;
    logic [31:0] hi_b;
    logic [31:0] tmp;
    int          n_items;
    in_item_t    it;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    fail_cnt   = 0;
    n_in       = 0;
    n_out      = 0;
    n_rejected = 0;
    n_cfg      = 0;
    cycle_cnt  = 0;
    pred_lower = 0;
    pred_upper = 256;
    pred_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].act)
        ACT_ITEM: begin
          it.kind    = plan[i].kind;
          it.operand = plan[i].value;
          send_item(it, plan[i].typed, plan[i].exp_count, plan[i].exp_err);
        end
        ACT_LOWER: write_bound(REG_LOWER, plan[i].value);
        default:   write_bound(REG_UPPER, plan[i].value);
      endcase
    end

    // random phases, one range setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      n_items = PHASE_ITEMS;
      case (ph)
        0: begin
          lo_b = 32'd0;
          hi_b = 32'd256;
        end
        1: begin
          lo_b = 32'h8000_0000;
          hi_b = 32'h7FFF_FFFF;
        end
        2: begin
          lo_b = 32'hFFFF_FFF6;
          hi_b = 32'hFFFF_FFFD;
        end
        3: begin
          lo_b = $urandom_range(0, 2000) - 1000;
          hi_b = lo_b + $urandom_range(1, 64);
        end
        4: begin
          lo_b = 32'h7FFF_FFFE;
          hi_b = 32'h7FFF_FFFF;
        end
        5: begin
          lo_b = 32'h8000_0000;
          hi_b = 32'h8000_0001;
        end
        6: begin
          lo_b = $urandom;
          hi_b = $urandom;
          if ($signed(lo_b) > $signed(hi_b)) begin
            tmp  = lo_b;
            lo_b = hi_b;
            hi_b = tmp;
          end
        end
        7: begin
          lo_b = 32'hC000_0000;
          hi_b = 32'h4000_0000 + $urandom_range(0, 1 << 20);
        end
        8: begin
          // empty range: every transfer is rejected
          lo_b    = 32'd500;
          hi_b    = 32'hFFFF_FE0C;
          n_items = EMPTY_ITEMS;
        end
        9: begin
          lo_b = 32'hFFFF_FFFB;
          hi_b = 32'd5;
        end
        10: begin
          lo_b = $urandom_range(0, 2000) - 1000;
          hi_b = lo_b + $urandom_range(1, 300);
        end
        default: begin
          lo_b = 32'h8000_0007;
          hi_b = 32'h7FFF_FFFD;
        end
      endcase
      write_bound(REG_LOWER, lo_b);
      write_bound(REG_UPPER, hi_b);
      no_idle = (ph == 5 || ph == 9);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      repeat (n_items) send_item(random_item(), 1'b0, 32'd0, 1'b0);
    end

    // drain
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input and %0d result transfers, %0d rejected, %0d bound writes",
             n_in, n_out, n_rejected, n_cfg);
    $display("ranges: reset, full, single value at both ends, negative, empty, random");
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rwac_pkg.sv
rtl/rwac_div.sv
rtl/range_wrapped_arithmetic_counter_unit.sv
test/tb_top.sv
